[rtl/iff_pkg.sv]
// ----------------------------------------------------------------------------
// iff_pkg
// Shared types, codes and sizes of the integer field formatter.
// ----------------------------------------------------------------------------
package iff_pkg;

	localparam int VALUE_BITS = 64;
	localparam int MAX_FIELD  = 64;
	localparam int EMIT_LIMIT = (MAX_FIELD < 64) ? MAX_FIELD : 64;
	localparam int PLAIN_BITS = (VALUE_BITS < 32) ? VALUE_BITS : 32;

	localparam int NDIG   = (VALUE_BITS + 2) / 3;
	localparam int DIG_W  = 4 * NDIG;
	localparam int NDIG_W = $clog2(NDIG + 1);
	localparam int CNT_W  = $clog2(VALUE_BITS);
	localparam int POS_W  = $clog2(EMIT_LIMIT + 1);
	localparam int BND_W  = 8;

	localparam logic [2:0] CMD_SDEC = 3'd0;
	localparam logic [2:0] CMD_UDEC = 3'd1;
	localparam logic [2:0] CMD_OCT  = 3'd2;
	localparam logic [2:0] CMD_HEXL = 3'd3;
	localparam logic [2:0] CMD_HEXU = 3'd4;
	localparam logic [2:0] CMD_PTR  = 3'd5;

	localparam logic [1:0] SZ_PLAIN = 2'd0;
	localparam logic [1:0] SZ_LONG  = 2'd1;
	localparam logic [1:0] SZ_SHORT = 2'd2;

	localparam logic [2:0] FL_NONE  = 3'd0;
	localparam logic [2:0] FL_MINUS = 3'd1;
	localparam logic [2:0] FL_PLUS  = 3'd2;
	localparam logic [2:0] FL_SPACE = 3'd3;
	localparam logic [2:0] FL_HASH  = 3'd4;
	localparam logic [2:0] FL_ZERO  = 3'd5;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_XL    = 8'h78;
	localparam logic [7:0] CH_XU    = 8'h58;
	localparam logic [7:0] CH_AL    = 8'h61;
	localparam logic [7:0] CH_AU    = 8'h41;

	typedef enum logic [2:0] {
		CV_HOLD,
		CV_LOAD_DEC,
		CV_LOAD_OCT,
		CV_LOAD_HEX,
		CV_DABBLE,
		CV_SHIFT
	} conv_op_t;

	typedef struct packed {
		logic [BND_W-1:0] pre_start;
		logic [BND_W-1:0] zero_start;
		logic [BND_W-1:0] digit_start;
		logic [BND_W-1:0] digit_end;
	} bound_t;

	function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
		logic [7:0] base;
		base = upper ? CH_AU : CH_AL;
		if (nib < 4'd10)
			digit_char = CH_ZERO + {4'd0, nib};
		else
			digit_char = base + {4'd0, nib} - 8'd10;
	endfunction

endpackage

[rtl/iff_conv.sv]
// ----------------------------------------------------------------------------
// iff_conv
// Shared digit register: binary to BCD by shift and add-3, direct octal and
// hex split, and a nibble shifter that serves normalization and digit output.
// ----------------------------------------------------------------------------
module iff_conv import iff_pkg::*; (
	input  logic                  clk,
	input  conv_op_t              op,
	input  logic [VALUE_BITS-1:0] mag,
	output logic [3:0]            top_nib
);

	logic [DIG_W-1:0]      dig_q;
	logic [VALUE_BITS-1:0] shf_q;
	logic [DIG_W-1:0]      adj;
	logic [DIG_W-1:0]      oct;
	logic [3*NDIG-1:0]     mext;

	always_comb begin
		mext = (3*NDIG)'(mag);
		for (int k = 0; k < NDIG; k++) begin
			oct[4*k +: 4] = {1'b0, mext[3*k +: 3]};
			adj[4*k +: 4] = (dig_q[4*k +: 4] >= 4'd5) ? dig_q[4*k +: 4] + 4'd3
				: dig_q[4*k +: 4];
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			CV_LOAD_DEC: begin
				dig_q <= '0;
				shf_q <= mag;
			end
			CV_LOAD_OCT: dig_q <= oct;
			CV_LOAD_HEX: dig_q <= DIG_W'(mag);
			CV_DABBLE: begin
				dig_q <= {adj[DIG_W-2:0], shf_q[VALUE_BITS-1]};
				shf_q <= {shf_q[VALUE_BITS-2:0], 1'b0};
			end
			CV_SHIFT: dig_q <= {dig_q[DIG_W-5:0], 4'd0};
			default: ;
		endcase
	end

	assign top_nib = dig_q[DIG_W-1 -: 4];

endmodule

[rtl/iff_emit.sv]
// ----------------------------------------------------------------------------
// iff_emit
// Character select for one output position: padding, prefix, zeros, digits.
// ----------------------------------------------------------------------------
module iff_emit import iff_pkg::*; (
	input  logic [POS_W-1:0] pos,
	input  bound_t           bnd,
	input  logic [7:0]       pre0,
	input  logic [7:0]       pre1,
	input  logic [3:0]       nib,
	input  logic             upper,
	output logic [7:0]       ch,
	output logic             is_digit
);

	logic [BND_W-1:0] p;

	always_comb begin
		p        = BND_W'(pos);
		is_digit = 1'b0;
		if (p < bnd.pre_start)
			ch = CH_SPACE;
		else if (p < bnd.zero_start)
			ch = (p == bnd.pre_start) ? pre0 : pre1;
		else if (p < bnd.digit_start)
			ch = CH_ZERO;
		else if (p < bnd.digit_end) begin
			ch       = digit_char(nib, upper);
			is_digit = 1'b1;
		end else
			ch = CH_SPACE;
	end

endmodule

[rtl/integer_field_formatter.sv]
// ----------------------------------------------------------------------------
// integer_field_formatter
// Printf-style integer conversion, one formatted character per strobe.
// ----------------------------------------------------------------------------
// Sequence: the request is accepted into registers, then for decimal a load and
// add-3 shift steps over every value bit, normalize steps that drop leading
// zero digits, three setup steps and emission; octal and hex skip the shifting.
// A new request is taken only after the last emitted character (at most 64 per
// request) has been produced; busy stays high until the last character.
// Reset clears the sequencer and the strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module integer_field_formatter import iff_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [63:0]           raw_value,
	input  logic [2:0]            command,
	input  logic [1:0]            size_mode,
	input  logic [2:0]            flag_code,
	input  logic [6:0]            field_width,
	input  logic signed [6:0]     digit_precision,
	output logic                  strobe,
	output logic [7:0]            out_char,
	output logic                  last_char
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_PREP, ST_DAB, ST_NORM, ST_CALC1, ST_CALC2, ST_CALC3, ST_EMIT
	} state_t;

	state_t                state_q;
	logic [VALUE_BITS-1:0] v_q;
	logic [2:0]            cmd_q;
	logic [2:0]            flag_q;
	logic [1:0]            sz_q;
	logic [6:0]            width_q;
	logic                  given_q;
	logic [5:0]            prec_q;
	logic                  neg_q;
	logic                  vz_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [NDIG_W-1:0]     ndig_q;
	logic [NDIG_W-1:0]     d_q;
	logic [1:0]            plen_q;
	logic [6:0]            zeros_q;
	logic [7:0]            pre0_q;
	logic [7:0]            pre1_q;
	logic                  upper_q;
	logic [6:0]            spaces_q;
	logic [BND_W-1:0]      c0_q;
	logic [BND_W-1:0]      body_q;
	bound_t                bnd_q;
	logic [POS_W-1:0]      lim_q;
	logic [POS_W-1:0]      pos_q;
	logic                  strobe_q;
	logic [7:0]            out_char_q;
	logic                  last_q;

	logic [2:0]            acc_cmd;
	logic [2:0]            acc_flag;
	logic [1:0]            acc_sz;
	logic                  acc_given;
	logic [VALUE_BITS-1:0] acc_v;
	logic                  acc_sign;
	logic [VALUE_BITS-1:0] mask_q;
	logic [VALUE_BITS-1:0] mag_c;
	conv_op_t              op;
	logic [3:0]            top_nib;
	logic [7:0]            ch;
	logic                  is_digit;

	logic                  nodig;
	logic [NDIG_W-1:0]     d_c;
	logic [1:0]            plen_c;
	logic [7:0]            pre0_c;
	logic [6:0]            zeros_c;
	logic [7:0]            zt;
	logic [BND_W-1:0]      body_c;
	logic [BND_W-1:0]      total_c;
	logic [6:0]            lead_c;
	logic [POS_W-1:0]      lim_c;

	function automatic logic [VALUE_BITS-1:0] size_mask(input logic [1:0] sz);
		case (sz)
			SZ_LONG:  size_mask = '1;
			SZ_SHORT: size_mask = VALUE_BITS'({16{1'b1}});
			default:  size_mask = VALUE_BITS'({PLAIN_BITS{1'b1}});
		endcase
	endfunction

	always_comb begin
		acc_cmd   = (command > CMD_PTR) ? CMD_UDEC : command;
		acc_sz    = (size_mode == 2'd3) ? SZ_PLAIN : size_mode;
		acc_flag  = (flag_code > FL_ZERO) ? FL_NONE : flag_code;
		acc_given = ~digit_precision[6];
		if (acc_cmd == CMD_PTR) begin
			acc_sz    = SZ_LONG;
			acc_flag  = (acc_flag == FL_MINUS) ? FL_MINUS : FL_NONE;
			acc_given = 1'b0;
		end
		acc_v = raw_value[VALUE_BITS-1:0] & size_mask(acc_sz);
		case (acc_sz)
			SZ_LONG:  acc_sign = acc_v[VALUE_BITS-1];
			SZ_SHORT: acc_sign = acc_v[15];
			default:  acc_sign = acc_v[PLAIN_BITS-1];
		endcase
	end

	assign mask_q = size_mask(sz_q);
	assign mag_c  = neg_q ? ((~v_q + VALUE_BITS'(1)) & mask_q) : v_q;

	always_comb begin
		nodig = given_q && (prec_q == 6'd0) && vz_q;
		d_c   = nodig ? '0 : ndig_q;

		plen_c = 2'd0;
		pre0_c = CH_ZERO;
		if (neg_q) begin
			plen_c = 2'd1;
			pre0_c = CH_MINUS;
		end else if (cmd_q == CMD_SDEC && flag_q == FL_PLUS) begin
			plen_c = 2'd1;
			pre0_c = CH_PLUS;
		end else if (cmd_q == CMD_SDEC && flag_q == FL_SPACE) begin
			plen_c = 2'd1;
			pre0_c = CH_SPACE;
		end else if (cmd_q == CMD_PTR || ((cmd_q == CMD_HEXL || cmd_q == CMD_HEXU) &&
				flag_q == FL_HASH && !vz_q)) begin
			plen_c = 2'd2;
			pre0_c = CH_ZERO;
		end

		zt      = {1'b0, width_q} - {6'd0, plen_c} - 8'(d_c);
		zeros_c = 7'd0;
		if (given_q) begin
			if ({1'b0, prec_q} > 7'(d_c))
				zeros_c = {1'b0, prec_q} - 7'(d_c);
		end else if (flag_q == FL_ZERO) begin
			if (!zt[7])
				zeros_c = zt[6:0];
		end
		if (cmd_q == CMD_OCT && flag_q == FL_HASH && zeros_c == 7'd0 &&
				(d_c == '0 || !vz_q))
			zeros_c = 7'd1;
	end

	always_comb begin
		body_c  = BND_W'(plen_q) + BND_W'(zeros_q) + BND_W'(d_q);
		lead_c  = (flag_q != FL_MINUS) ? spaces_q : 7'd0;
		total_c = BND_W'(spaces_q) + body_q;
		lim_c   = (total_c > BND_W'(EMIT_LIMIT)) ? POS_W'(EMIT_LIMIT) : POS_W'(total_c);
	end

	always_comb begin
		op = CV_HOLD;
		case (state_q)
			ST_PREP: begin
				if (cmd_q == CMD_OCT)
					op = CV_LOAD_OCT;
				else if (cmd_q == CMD_HEXL || cmd_q == CMD_HEXU || cmd_q == CMD_PTR)
					op = CV_LOAD_HEX;
				else
					op = CV_LOAD_DEC;
			end
			ST_DAB:  op = CV_DABBLE;
			ST_NORM: if (ndig_q > NDIG_W'(1) && top_nib == 4'd0) op = CV_SHIFT;
			ST_EMIT: if (is_digit) op = CV_SHIFT;
			default: op = CV_HOLD;
		endcase
	end

	iff_conv u_conv (
		.clk     (clk),
		.op      (op),
		.mag     (mag_c),
		.top_nib (top_nib)
	);

	iff_emit u_emit (
		.pos      (pos_q),
		.bnd      (bnd_q),
		.pre0     (pre0_q),
		.pre1     (pre1_q),
		.nib      (top_nib),
		.upper    (upper_q),
		.ch       (ch),
		.is_digit (is_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			v_q        <= '0;
			cmd_q      <= CMD_SDEC;
			flag_q     <= FL_NONE;
			sz_q       <= SZ_PLAIN;
			width_q    <= '0;
			given_q    <= 1'b0;
			prec_q     <= '0;
			neg_q      <= 1'b0;
			vz_q       <= 1'b0;
			cnt_q      <= '0;
			ndig_q     <= '0;
			d_q        <= '0;
			plen_q     <= '0;
			zeros_q    <= '0;
			pre0_q     <= CH_ZERO;
			pre1_q     <= CH_XL;
			upper_q    <= 1'b0;
			spaces_q   <= '0;
			c0_q       <= '0;
			body_q     <= '0;
			bnd_q      <= '0;
			lim_q      <= '0;
			pos_q      <= '0;
			strobe_q   <= 1'b0;
			out_char_q <= '0;
			last_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						v_q     <= acc_v;
						cmd_q   <= acc_cmd;
						flag_q  <= acc_flag;
						sz_q    <= acc_sz;
						width_q <= field_width;
						given_q <= acc_given;
						prec_q  <= digit_precision[5:0];
						neg_q   <= (acc_cmd == CMD_SDEC) && acc_sign;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					vz_q    <= (v_q == '0);
					upper_q <= (cmd_q == CMD_HEXU);
					cnt_q   <= '0;
					ndig_q  <= NDIG_W'(NDIG);
					if (cmd_q == CMD_SDEC || cmd_q == CMD_UDEC)
						state_q <= ST_DAB;
					else
						state_q <= ST_NORM;
				end
				ST_DAB: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(VALUE_BITS - 1))
						state_q <= ST_NORM;
				end
				ST_NORM: begin
					if (ndig_q > NDIG_W'(1) && top_nib == 4'd0)
						ndig_q <= ndig_q - NDIG_W'(1);
					else
						state_q <= ST_CALC1;
				end
				ST_CALC1: begin
					d_q     <= d_c;
					plen_q  <= plen_c;
					pre0_q  <= pre0_c;
					pre1_q  <= upper_q ? CH_XU : CH_XL;
					zeros_q <= zeros_c;
					state_q <= ST_CALC2;
				end
				ST_CALC2: begin
					body_q   <= body_c;
					c0_q     <= BND_W'(plen_q) + BND_W'(zeros_q);
					spaces_q <= (BND_W'(width_q) > body_c) ? width_q - body_c[6:0] : 7'd0;
					state_q  <= ST_CALC3;
				end
				ST_CALC3: begin
					bnd_q.pre_start   <= BND_W'(lead_c);
					bnd_q.zero_start  <= BND_W'(lead_c) + BND_W'(plen_q);
					bnd_q.digit_start <= BND_W'(lead_c) + c0_q;
					bnd_q.digit_end   <= BND_W'(lead_c) + body_q;
					lim_q             <= lim_c;
					pos_q             <= '0;
					state_q           <= (lim_c == '0) ? ST_IDLE : ST_EMIT;
				end
				ST_EMIT: begin
					strobe_q   <= 1'b1;
					out_char_q <= ch;
					last_q     <= (pos_q == lim_q - POS_W'(1));
					pos_q      <= pos_q + POS_W'(1);
					if (pos_q == lim_q - POS_W'(1))
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign strobe    = strobe_q;
	assign out_char  = out_char_q;
	assign last_char = last_q;

	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_char |=> strobe)
		else $error("character stream broken before last character");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_char |=> !strobe)
		else $error("strobe continues after last character");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !strobe)
		else $error("accepted request did not raise busy");

	a_strobe_owned: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy || last_char)
		else $error("strobe while idle outside last character");

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer field formatter. A scoreboard builds
// the expected character stream of every accepted request and checks each
// strobed character against it. Directed requests cover the corner cases;
// a random phase mixes kinds, sizes, flags, widths and precisions.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
	import iff_pkg::*;

	localparam int RANDOM_REQUESTS = 360;
	localparam int CYCLE_LIMIT     = 600000;
	localparam int DRAIN_CYCLES    = 150;

	typedef struct {
		logic [63:0] raw_value;
		logic [2:0]  command;
		logic [1:0]  size_mode;
		logic [2:0]  flag_code;
		logic [6:0]  field_width;
		logic [6:0]  digit_precision;
	} fmt_request_t;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} fmt_char_t;

	class field_scoreboard;
		fmt_char_t   pending_chars[$];
		int unsigned error_count;
		int unsigned request_count;
		int unsigned empty_fields;
		int unsigned checked_chars;

		function int pending_count();
			return pending_chars.size();
		endfunction

		function void note_request(fmt_request_t req);
			logic [2:0]  cmd;
			logic [1:0]  size;
			logic [2:0]  flag;
			int          width;
			int          prec;
			bit          given;
			int          bits;
			logic [63:0] mask;
			logic [63:0] v;
			logic [63:0] mag;
			logic [63:0] base;
			bit          neg;
			bit          upper;
			logic [7:0]  digs[64];
			logic [7:0]  prefix[$];
			logic [7:0]  field[$];
			int          n;
			int          d;
			int          zeros;
			int          spaces;
			int          emit_n;
			fmt_char_t   fc;

			cmd   = req.command;
			size  = req.size_mode;
			flag  = req.flag_code;
			width = int'(req.field_width);
			prec  = int'($signed(req.digit_precision));
			given = prec >= 0;
			if (cmd > CMD_PTR)
				cmd = CMD_UDEC;
			if (size == 2'd3)
				size = SZ_PLAIN;
			if (flag > FL_ZERO)
				flag = FL_NONE;

			if (cmd == CMD_PTR || size == SZ_LONG)
				bits = VALUE_BITS;
			else if (size == SZ_SHORT)
				bits = 16;
			else
				bits = PLAIN_BITS;
			mask = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);

			v   = req.raw_value & mask;
			neg = (cmd == CMD_SDEC) && v[bits-1];
			mag = neg ? ((~v + 64'd1) & mask) : v;

			base  = (cmd <= CMD_UDEC) ? 64'd10 : ((cmd == CMD_OCT) ? 64'd8 : 64'd16);
			upper = cmd == CMD_HEXU;

			if (cmd == CMD_PTR) begin
				given = 1'b0;
				if (flag != FL_MINUS)
					flag = FL_NONE;
			end

			n = 0;
			if (!(given && prec == 0 && mag == 64'd0)) begin
				do begin
					d = int'(mag % base);
					if (d < 10)
						digs[n] = CH_ZERO + 8'(d);
					else
						digs[n] = (upper ? CH_AU : CH_AL) + 8'(d - 10);
					mag = mag / base;
					n++;
				end while (mag != 64'd0 && n < 64);
			end

			if (neg) begin
				prefix.push_back(CH_MINUS);
			end else if (cmd == CMD_SDEC && flag == FL_PLUS) begin
				prefix.push_back(CH_PLUS);
			end else if (cmd == CMD_SDEC && flag == FL_SPACE) begin
				prefix.push_back(CH_SPACE);
			end else if (cmd == CMD_PTR ||
					((cmd == CMD_HEXL || cmd == CMD_HEXU) && flag == FL_HASH && v != 64'd0)) begin
				prefix.push_back(CH_ZERO);
				prefix.push_back(upper ? CH_XU : CH_XL);
			end

			zeros = 0;
			if (given) begin
				if (prec > n)
					zeros = prec - n;
			end else if (flag == FL_ZERO) begin
				if (width - prefix.size() - n > 0)
					zeros = width - prefix.size() - n;
			end
			if (cmd == CMD_OCT && flag == FL_HASH && zeros == 0 &&
					(n == 0 || digs[n-1] != CH_ZERO))
				zeros = 1;

			spaces = width - (prefix.size() + zeros + n);
			if (spaces < 0)
				spaces = 0;

			if (flag != FL_MINUS)
				repeat (spaces) field.push_back(CH_SPACE);
			foreach (prefix[i])
				field.push_back(prefix[i]);
			repeat (zeros) field.push_back(CH_ZERO);
			for (int i = n - 1; i >= 0; i--)
				field.push_back(digs[i]);
			if (flag == FL_MINUS)
				repeat (spaces) field.push_back(CH_SPACE);

			emit_n = (field.size() > EMIT_LIMIT) ? EMIT_LIMIT : field.size();
			for (int i = 0; i < emit_n; i++) begin
				fc.ch   = field[i];
				fc.last = (i == emit_n - 1);
				pending_chars.push_back(fc);
			end
			request_count++;
			if (emit_n == 0)
				empty_fields++;
		endfunction

		function void check_char(logic [7:0] ch, logic last);
			fmt_char_t want;
			if (pending_chars.size() == 0) begin
				error_count++;
				$error("out_char: no character pending, actual %h (last_char %b)", ch, last);
				return;
			end
			want = pending_chars.pop_front();
			checked_chars++;
			if (ch !== want.ch) begin
				error_count++;
				$error("out_char: expected %h actual %h", want.ch, ch);
			end
			if (last !== want.last) begin
				error_count++;
				$error("last_char: expected %b actual %b", want.last, last);
			end
		endfunction
	endclass

	logic        clk             = 1'b0;
	logic        arst_n          = 1'b0;
	logic        start           = 1'b0;
	logic [63:0] raw_value       = '0;
	logic [2:0]  command         = CMD_SDEC;
	logic [1:0]  size_mode       = SZ_PLAIN;
	logic [2:0]  flag_code       = FL_NONE;
	logic [6:0]  field_width     = '0;
	logic [6:0]  digit_precision = '1;
	logic        busy;
	logic        strobe;
	logic [7:0]  out_char;
	logic        last_char;

	field_scoreboard sb = new();
	int unsigned     cycle_count = 0;
	int unsigned     directed_count = 0;

	always #6 clk = ~clk;

	integer_field_formatter u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.raw_value       (raw_value),
		.command         (command),
		.size_mode       (size_mode),
		.flag_code       (flag_code),
		.field_width     (field_width),
		.digit_precision (digit_precision),
		.strobe          (strobe),
		.out_char        (out_char),
		.last_char       (last_char)
	);

	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_char(out_char, last_char);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic fmt_request_t make_request(logic [63:0] v, logic [2:0] cmd,
			logic [1:0] size, logic [2:0] flag, int width, int prec);
		fmt_request_t r;
		r.raw_value       = v;
		r.command         = cmd;
		r.size_mode       = size;
		r.flag_code       = flag;
		r.field_width     = width[6:0];
		r.digit_precision = prec[6:0];
		return r;
	endfunction

	function automatic logic [63:0] random_value();
		case ($urandom_range(0, 9))
			0:       return 64'd0;
			1, 2:    return 64'($urandom_range(0, 999));
			3:       return '1;
			4:       return 64'd1 << $urandom_range(0, 63);
			5:       return (64'd1 << $urandom_range(0, 63)) - 64'd1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic fmt_request_t random_request();
		fmt_request_t r;
		int           pick;
		r.raw_value = random_value();
		r.command   = ($urandom_range(0, 99) < 94) ? 3'($urandom_range(0, 5))
		                                           : 3'($urandom_range(6, 7));
		r.size_mode = ($urandom_range(0, 99) < 92) ? 2'($urandom_range(0, 2)) : 2'd3;
		r.flag_code = ($urandom_range(0, 99) < 90) ? 3'($urandom_range(0, 5))
		                                           : 3'($urandom_range(6, 7));
		pick = $urandom_range(0, 99);
		if (pick < 70)
			r.field_width = 7'($urandom_range(0, 16));
		else if (pick < 92)
			r.field_width = 7'($urandom_range(17, 40));
		else
			r.field_width = 7'($urandom_range(41, 127));
		pick = $urandom_range(0, 99);
		if (pick < 45)
			r.digit_precision = '1;
		else if (pick < 85)
			r.digit_precision = 7'($urandom_range(0, 24));
		else
			r.digit_precision = 7'($urandom_range(0, 127));
		return r;
	endfunction

	function automatic int pick_gap(int idx);
		int pick;
		if ((idx / 40) % 3 == 1)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 15);
		return $urandom_range(40, 200);
	endfunction

	// Hold start until the block takes the request; with a nonzero gap_after, start then drops for that gap.
	task automatic send_request(fmt_request_t req, int gap_after);
		start           <= 1'b1;
		raw_value       <= req.raw_value;
		command         <= req.command;
		size_mode       <= req.size_mode;
		flag_code       <= req.flag_code;
		field_width     <= req.field_width;
		digit_precision <= req.digit_precision;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		sb.note_request(req);
		if (gap_after > 0) begin
			start <= 1'b0;
			repeat (gap_after) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		while (sb.pending_count() != 0)
			@(posedge clk);
	endtask

	initial begin
		fmt_request_t directed[$];

		directed.push_back(make_request(64'd0, CMD_SDEC, SZ_PLAIN, FL_NONE, 0, -1));
		directed.push_back(make_request(64'h8000_0000, CMD_SDEC, SZ_PLAIN, FL_NONE, 0, -1));
		directed.push_back(make_request('1, CMD_SDEC, SZ_LONG, FL_NONE, 0, -1));
		directed.push_back(make_request(64'h8000_0000_0000_0000, CMD_SDEC, SZ_LONG,
			FL_NONE, 0, -1));
		directed.push_back(make_request('1, CMD_UDEC, SZ_LONG, FL_NONE, 0, -1));
		directed.push_back(make_request(64'd42, CMD_SDEC, SZ_PLAIN, FL_PLUS, 0, -1));
		directed.push_back(make_request(64'd7, CMD_SDEC, SZ_PLAIN, FL_SPACE, 5, -1));
		directed.push_back(make_request(-64'sd5, CMD_SDEC, SZ_PLAIN, FL_MINUS, 8, -1));
		directed.push_back(make_request(-64'sd123, CMD_SDEC, SZ_PLAIN, FL_ZERO, 10, -1));
		directed.push_back(make_request(64'd5, CMD_SDEC, SZ_PLAIN, FL_ZERO, 8, 3));
		directed.push_back(make_request(64'd0, CMD_UDEC, SZ_PLAIN, FL_NONE, 0, 0));
		directed.push_back(make_request(64'd0, CMD_HEXL, SZ_PLAIN, FL_NONE, 4, 0));
		directed.push_back(make_request(64'd8, CMD_OCT, SZ_PLAIN, FL_HASH, 0, -1));
		directed.push_back(make_request(64'd0, CMD_OCT, SZ_PLAIN, FL_HASH, 0, -1));
		directed.push_back(make_request(64'd0, CMD_OCT, SZ_PLAIN, FL_HASH, 3, 0));
		directed.push_back(make_request('1, CMD_OCT, SZ_LONG, FL_NONE, 0, -1));
		directed.push_back(make_request(64'hDEAD_BEEF, CMD_HEXL, SZ_PLAIN, FL_HASH, 0, -1));
		directed.push_back(make_request(64'h1234_BEEF, CMD_HEXU, SZ_SHORT, FL_HASH, 9, -1));
		directed.push_back(make_request(64'd0, CMD_HEXU, SZ_PLAIN, FL_HASH, 0, -1));
		directed.push_back(make_request('1, CMD_HEXU, SZ_LONG, FL_ZERO, 20, -1));
		directed.push_back(make_request(64'd0, CMD_PTR, SZ_SHORT, FL_PLUS, 0, 10));
		directed.push_back(make_request(64'hFFFF_0000_1234_ABCD, CMD_PTR, SZ_PLAIN,
			FL_MINUS, 24, -1));
		directed.push_back(make_request(64'h1234_8000, CMD_SDEC, SZ_SHORT, FL_NONE, 0, -1));
		directed.push_back(make_request(64'hFFFF_FFFF_0000_0001, 3'd7, 2'd3, 3'd6, 3, 7'h40));
		directed.push_back(make_request(64'h8000_0000_0000_0001, 3'd6, SZ_LONG, 3'd7, 127, 63));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_request(directed[i], $urandom_range(0, 2));
		directed_count = directed.size();
		wait_drained();

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i == RANDOM_REQUESTS / 2) begin
				send_request(random_request(), 1);
				wait_drained();
			end else begin
				send_request(random_request(), pick_gap(i));
			end
		end
		start <= 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests (%0d directed), %0d characters checked",
			sb.request_count, directed_count, sb.checked_chars);
		$display("empty fields: %0d, mismatches: %0d, characters still pending: %0d",
			sb.empty_fields, sb.error_count, sb.pending_count());
		if (sb.error_count == 0 && sb.pending_count() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
